FILE: rtl/fssc_pkg.sv
package fssc_pkg;

  localparam int NUM_DRIVES = 2;
  localparam int DRV_W      = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
  localparam bit MULTI_DRV  = (NUM_DRIVES > 1);

  localparam logic [7:0] MOTOR_OFF_DELAY_RST = 8'd60;
  localparam logic [6:0] MAX_HALF_TRACK_RST  = 7'd69;

  localparam logic       REG_MOTOR_OFF_DELAY = 1'b0;
  localparam logic       REG_MAX_HALF_TRACK  = 1'b1;

  localparam logic REQ_SWITCH = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [3:0] SW_MOTOR_OFF = 4'h8;
  localparam logic [3:0] SW_MOTOR_ON  = 4'h9;
  localparam logic [3:0] SW_DRIVE_1   = 4'hA;
  localparam logic [3:0] SW_DRIVE_2   = 4'hB;
  localparam logic [3:0] SW_LATCH     = 4'hC;
  localparam logic [3:0] SW_NOP       = 4'hD;
  localparam logic [3:0] SW_READ_MODE = 4'hE;
  localparam logic [3:0] SW_WRITE_MODE = 4'hF;

  typedef struct packed {
    logic [7:0] motor_off_delay;
    logic [6:0] max_half_track;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [3:0] switch_index;
    logic       has_write_data;
    logic [7:0] write_value;
    logic [7:0] disk_byte_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       disk_read_taken;
    logic       disk_write_strobe;
    logic [7:0] disk_write_byte;
    logic       motor_running;
    logic       second_drive_selected;
    logic [6:0] head_half_track;
    logic       writing_mode;
  } result_t;

endpackage

FILE: rtl/fssc_cfg.sv
module fssc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output fssc_pkg::cfg_t                 cfg
);
  import fssc_pkg::*;

  logic [7:0] delay_r;
  logic [6:0] max_ht_r;
  logic       wr_en;
  logic       reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= MOTOR_OFF_DELAY_RST;
      max_ht_r <= MAX_HALF_TRACK_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MOTOR_OFF_DELAY: delay_r  <= cfg_pwdata[7:0];
        REG_MAX_HALF_TRACK:  max_ht_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MOTOR_OFF_DELAY: cfg_prdata = {24'd0, delay_r};
      REG_MAX_HALF_TRACK:  cfg_prdata = {25'd0, max_ht_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.motor_off_delay = delay_r;
  assign cfg.max_half_track  = max_ht_r;

endmodule

FILE: rtl/fssc_core.sv
module fssc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  fssc_pkg::cfg_t    cfg,
  input  logic              step,
  input  fssc_pkg::item_t   item,
  output fssc_pkg::result_t res
);
  import fssc_pkg::*;

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] cog_r [NUM_DRIVES];
  logic [1:0] cog_nxt [NUM_DRIVES];
  logic [6:0] ht_r [NUM_DRIVES];
  logic [6:0] ht_nxt [NUM_DRIVES];
  logic       motor_r, motor_nxt;
  logic       drv2_r, drv2_nxt;
  logic       wmode_r, wmode_nxt;
  logic [7:0] latch_r, latch_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;
  logic [DRV_W-1:0] act, act_nxt;
  result_t    r;

  assign act     = (drv2_r && MULTI_DRV) ? DRV_W'(1) : '0;
  assign act_nxt = (drv2_nxt && MULTI_DRV) ? DRV_W'(1) : '0;

  always_comb begin
    logic [1:0] cog;
    logic [1:0] left;
    logic [1:0] right;
    logic [1:0] p;
    logic [7:0] dec;

    phase_nxt = phase_r;
    cog_nxt   = cog_r;
    ht_nxt    = ht_r;
    motor_nxt = motor_r;
    drv2_nxt  = drv2_r;
    wmode_nxt = wmode_r;
    latch_nxt = latch_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    r         = '0;
    cog       = cog_r[act];
    left      = cog - 2'd1;
    right     = cog + 2'd1;
    p         = item.switch_index[2:1];
    dec       = (cnt_r != 8'd0) ? cnt_r - 8'd1 : 8'd0;

    if (item.req_type == REQ_TICK) begin
      if (pend_r) begin
        cnt_nxt = dec;
        if (dec == 8'd0) begin
          motor_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end
      end
    end else begin
      if (pend_r) cnt_nxt = cfg.motor_off_delay;
      if (item.has_write_data) latch_nxt = item.write_value;
      if (!item.switch_index[3]) begin
        phase_nxt[p] = item.switch_index[0];
        if (!phase_nxt[cog] && phase_nxt[left]) begin
          cog_nxt[act] = left;
          if (ht_r[act] != 7'd0) ht_nxt[act] = ht_r[act] - 7'd1;
        end else if (!phase_nxt[cog] && phase_nxt[right]) begin
          cog_nxt[act] = right;
          if (ht_r[act] < cfg.max_half_track) ht_nxt[act] = ht_r[act] + 7'd1;
        end
      end else begin
        case (item.switch_index)
          SW_MOTOR_OFF: begin
            if (motor_r) begin
              pend_nxt = 1'b1;
              cnt_nxt  = cfg.motor_off_delay;
            end
          end
          SW_MOTOR_ON: begin
            pend_nxt  = 1'b0;
            cnt_nxt   = 8'd0;
            motor_nxt = 1'b1;
          end
          SW_DRIVE_1: drv2_nxt = 1'b0;
          SW_DRIVE_2: drv2_nxt = MULTI_DRV;
          SW_LATCH: begin
            if (motor_r) begin
              if (wmode_r) begin
                r.disk_write_strobe = 1'b1;
                r.disk_write_byte   = latch_nxt;
                latch_nxt           = 8'd0;
              end else begin
                r.disk_read_taken = 1'b1;
                r.read_data       = item.disk_byte_in;
                latch_nxt         = item.disk_byte_in;
              end
            end
          end
          SW_NOP: ;
          SW_READ_MODE:  wmode_nxt = 1'b0;
          SW_WRITE_MODE: wmode_nxt = 1'b1;
          default: ;
        endcase
      end
    end

    r.motor_running         = motor_nxt;
    r.second_drive_selected = drv2_nxt && MULTI_DRV;
    r.head_half_track       = ht_nxt[act_nxt];
    r.writing_mode          = wmode_nxt;
  end

  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      for (int i = 0; i < NUM_DRIVES; i++) begin
        cog_r[i] <= '0;
        ht_r[i]  <= '0;
      end
      motor_r <= 1'b0;
      drv2_r  <= 1'b0;
      wmode_r <= 1'b0;
      latch_r <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cog_r   <= cog_nxt;
      ht_r    <= ht_nxt;
      motor_r <= motor_nxt;
      drv2_r  <= drv2_nxt;
      wmode_r <= wmode_nxt;
      latch_r <= latch_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

FILE: rtl/floppy_soft_switch_controller_unit.sv
// Soft switch controller for a two-drive floppy interface. Each input
// transaction is either a soft switch access or one frame tick; each gives
// exactly one result transaction carrying any disk read or write plus the
// motor, drive, head and mode status after it. One transaction is taken per
// clock cycle while the result path is not stalled; it waits in the input
// register, and when it advances the controller state is updated and the
// result registered, then offered and held while out_tready is low.
// Registers: 0x0 motor-off delay in frame ticks, 0x4 highest half-track;
// write them only while the block is idle.
module floppy_soft_switch_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // switch_index, has_write_data, write_value, disk_byte_in
  input  logic        in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // read_data, disk_read_taken, disk_write_strobe,
                                 // disk_write_byte, motor_running, second_drive_selected,
                                 // head_half_track, writing_mode
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fssc_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    adv;
  logic    in_acc;

  fssc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_item.req_type       = in_tuser;
  assign in_item.switch_index   = in_tdata[3:0];
  assign in_item.has_write_data = in_tdata[4];
  assign in_item.write_value    = in_tdata[12:5];
  assign in_item.disk_byte_in   = in_tdata[20:13];

  assign adv       = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  fssc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (adv),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_item;
    if (adv) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0,
                       out_res_r.writing_mode,
                       out_res_r.head_half_track,
                       out_res_r.second_drive_selected,
                       out_res_r.motor_running,
                       out_res_r.disk_write_byte,
                       out_res_r.disk_write_strobe,
                       out_res_r.disk_read_taken,
                       out_res_r.read_data};

endmodule

FILE: sim/floppy_soft_switch_controller_unit_tb.sv
module floppy_soft_switch_controller_unit_tb;
  import fssc_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int NUM_PHASES      = 6;
  localparam logic [2:0] ADDR_MOTOR_OFF_DELAY = {REG_MOTOR_OFF_DELAY, 2'b00};
  localparam logic [2:0] ADDR_MAX_HALF_TRACK  = {REG_MAX_HALF_TRACK, 2'b00};
  localparam logic MAGNET_ON  = 1'b1;
  localparam logic MAGNET_OFF = 1'b0;

  typedef struct {
    logic       req;
    logic [3:0] sw;
    logic       has_wr;
    logic [7:0] wval;
    logic [7:0] dbyte;
    bit         hold;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       taken;
    logic       strobe;
    logic [7:0] wbyte;
    logic       motor;
    logic       drive2;
    logic [6:0] half_track;
    logic       wmode;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;  // switch_index, has_write_data, write_value, disk_byte_in
  logic        in_tuser;  // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata; // read_data, disk_read_taken, disk_write_strobe, disk_write_byte,
                          // motor_running, second_drive_selected, head_half_track,
                          // writing_mode
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  floppy_soft_switch_controller_unit dut (.*);

  // controller state as predicted
  logic [3:0] magnets;
  logic [1:0] cog [2];
  logic [6:0] half_track [2];
  logic       spin_on;
  logic       sel_drv2;
  logic       wr_mode;
  logic       stop_pending;
  logic [7:0] data_latch;
  logic [7:0] stop_countdown;
  logic [7:0] off_delay;
  logic [6:0] max_track;

  access_t stim_q[$];
  status_t status_q[$];
  access_t on_bus;
  bit      in_pending;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      mismatches;
  int      stall_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic status_t step_controller(input access_t a);
    status_t    s;
    logic [1:0] c;
    logic [1:0] l;
    logic [1:0] r;
    s = '0;
    if (a.req == REQ_TICK) begin
      if (stop_pending) begin
        if (stop_countdown != 0) stop_countdown--;
        if (stop_countdown == 0) begin
          spin_on = 1'b0;
          stop_pending = 1'b0;
        end
      end
    end else begin
      if (stop_pending) stop_countdown = off_delay;
      if (a.has_wr) data_latch = a.wval;
      if (!a.sw[3]) begin
        magnets[a.sw[2:1]] = a.sw[0];
        c = cog[sel_drv2];
        l = c - 2'd1;
        r = c + 2'd1;
        if (!magnets[c] && magnets[l]) begin
          cog[sel_drv2] = l;
          if (half_track[sel_drv2] != 0) half_track[sel_drv2]--;
        end else if (!magnets[c] && magnets[r]) begin
          cog[sel_drv2] = r;
          if (half_track[sel_drv2] < max_track) half_track[sel_drv2]++;
        end
      end else begin
        case (a.sw)
          SW_MOTOR_OFF: begin
            if (spin_on) begin
              stop_pending = 1'b1;
              stop_countdown = off_delay;
            end
          end
          SW_MOTOR_ON: begin
            stop_pending = 1'b0;
            stop_countdown = '0;
            spin_on = 1'b1;
          end
          SW_DRIVE_1: sel_drv2 = 1'b0;
          SW_DRIVE_2: begin
            if (MULTI_DRV) sel_drv2 = 1'b1;
          end
          SW_LATCH: begin
            if (spin_on && wr_mode) begin
              s.strobe = 1'b1;
              s.wbyte = data_latch;
              data_latch = '0;
            end else if (spin_on) begin
              s.taken = 1'b1;
              s.read_data = a.dbyte;
              data_latch = a.dbyte;
            end
          end
          SW_READ_MODE:  wr_mode = 1'b0;
          SW_WRITE_MODE: wr_mode = 1'b1;
          default: ;
        endcase
      end
    end
    s.motor = spin_on;
    s.drive2 = sel_drv2;
    s.half_track = half_track[sel_drv2];
    s.wmode = wr_mode;
    return s;
  endfunction

  function automatic string status_str(input status_t s);
    return $sformatf("rd=%h taken=%b strobe=%b wbyte=%h motor=%b drive2=%b track=%0d wmode=%b",
                     s.read_data, s.taken, s.strobe, s.wbyte, s.motor, s.drive2,
                     s.half_track, s.wmode);
  endfunction

  function automatic logic [3:0] phase_switch(input logic [1:0] p, input logic energise);
    return {1'b0, p, energise};
  endfunction

  function automatic void add_access(input logic req, input logic [3:0] sw,
                                     input logic has_wr, input logic [7:0] wval,
                                     input logic [7:0] dbyte, input bit hold = 1'b0);
    access_t a;
    a.req = req;
    a.sw = sw;
    a.has_wr = has_wr;
    a.wval = wval;
    a.dbyte = dbyte;
    a.hold = hold;
    stim_q.push_back(a);
  endfunction

  function automatic void add_switch(input logic [3:0] sw, input bit hold = 1'b0);
    add_access(REQ_SWITCH, sw, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), hold);
  endfunction

  function automatic void add_tick();
    add_access(REQ_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // locks onto the cog within two steps whatever its start position
  function automatic void add_seek(input bit up, input int steps, input bit hold);
    logic [1:0] p;
    logic [1:0] nxt;
    bit         overlap;
    int         i;
    p = 2'($urandom_range(0, 3));
    overlap = 1'($urandom_range(0, 1));
    for (i = 0; i < 4; i++) add_switch(phase_switch(2'(i), MAGNET_OFF), hold && i == 0);
    if (overlap) add_switch(phase_switch(p, MAGNET_ON));
    for (i = 0; i < steps; i++) begin
      nxt = up ? p + 2'd1 : p - 2'd1;
      if (overlap) begin
        add_switch(phase_switch(nxt, MAGNET_ON));
        add_switch(phase_switch(p, MAGNET_OFF));
      end else begin
        add_switch(phase_switch(p, MAGNET_ON));
        add_switch(phase_switch(p, MAGNET_OFF));
      end
      p = nxt;
    end
  endfunction

  function automatic void add_burst();
    int kind;
    int n;
    int i;
    bit hold;
    hold = ($urandom_range(0, 24) == 0);
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      add_seek(1'($urandom_range(0, 1)), $urandom_range(1, 40), hold);
    end else if (kind < 60) begin
      add_switch(SW_MOTOR_ON, hold);
      add_switch($urandom_range(0, 1) ? SW_READ_MODE : SW_WRITE_MODE);
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0)
          add_switch($urandom_range(0, 1) ? SW_READ_MODE : SW_WRITE_MODE);
        add_switch(SW_LATCH);
      end
    end else if (kind < 75) begin
      if ($urandom_range(0, 1)) add_switch(SW_MOTOR_ON, hold);
      add_switch(SW_MOTOR_OFF, hold);
      if (off_delay <= 20 || $urandom_range(0, 5) == 0)
        n = int'(off_delay) + $urandom_range(0, 3) - 1;
      else
        n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) add_switch(SW_NOP);
        else add_tick();
      end
    end else if (kind < 85) begin
      add_switch($urandom_range(0, 1) ? SW_DRIVE_1 : SW_DRIVE_2, hold);
      add_seek(1'($urandom_range(0, 1)), $urandom_range(1, 12), 1'b0);
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        add_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), hold && i == 0);
    end
  endfunction

  task automatic wait_idle();
    while (stim_q.size() != 0 || in_pending || status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_MOTOR_OFF_DELAY) off_delay = data[7:0];
    else max_track = data[6:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus: send on falling edges
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_pending) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(stim_q[0].hold && status_q.size() != 0)) begin
          on_bus = stim_q.pop_front();
          in_pending = 1'b1;
          in_tvalid <= 1'b1;
          in_tuser <= on_bus.req;
          in_tdata <= {3'b000, on_bus.dbyte, on_bus.wval, on_bus.has_wr, on_bus.sw};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // transactions taken on rising edges; results checked before new predictions
  always @(posedge clk) begin
    status_t got;
    status_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_n && out_tvalid && out_tready) begin
      moved = 1'b1;
      got.read_data = out_tdata[7:0];
      got.taken = out_tdata[8];
      got.strobe = out_tdata[9];
      got.wbyte = out_tdata[17:10];
      got.motor = out_tdata[18];
      got.drive2 = out_tdata[19];
      got.half_track = out_tdata[26:20];
      got.wmode = out_tdata[27];
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", status_str(got));
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch");
            $display("  exp %s", status_str(want));
            $display("  got %s", status_str(got));
          end
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      moved = 1'b1;
      status_q.push_back(step_controller(on_bus));
      in_pending = 1'b0;
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("floppy_soft_switch_controller_unit test failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int target;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_pending = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 53;
    magnets = '0;
    cog[0] = '0;
    cog[1] = '0;
    half_track[0] = '0;
    half_track[1] = '0;
    spin_on = 1'b0;
    sel_drv2 = 1'b0;
    wr_mode = 1'b0;
    stop_pending = 1'b0;
    data_latch = '0;
    stop_countdown = '0;
    off_delay = MOTOR_OFF_DELAY_RST;
    max_track = MAX_HALF_TRACK_RST;

    add_access(REQ_TICK,   SW_NOP,        1'b1, 8'hFF, 8'hFF);
    add_access(REQ_SWITCH, SW_MOTOR_OFF,  1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_LATCH,      1'b1, 8'hFF, 8'h00);
    add_access(REQ_SWITCH, SW_MOTOR_ON,   1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_LATCH,      1'b0, 8'h00, 8'hFF);
    add_access(REQ_SWITCH, SW_LATCH,      1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_WRITE_MODE, 1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_LATCH,      1'b1, 8'hA5, 8'h5A);
    add_access(REQ_SWITCH, SW_LATCH,      1'b0, 8'h00, 8'hFF);
    add_access(REQ_SWITCH, SW_READ_MODE,  1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd1, MAGNET_ON),  1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd1, MAGNET_OFF), 1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd0, MAGNET_ON),  1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd0, MAGNET_OFF), 1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd3, MAGNET_ON),  1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd3, MAGNET_OFF), 1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_DRIVE_2,    1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd1, MAGNET_ON),  1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, phase_switch(2'd1, MAGNET_OFF), 1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_DRIVE_1,    1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_MOTOR_OFF,  1'b0, 8'h00, 8'h00);
    add_access(REQ_TICK,   SW_MOTOR_ON,   1'b0, 8'h00, 8'h00, 1'b1);
    add_access(REQ_SWITCH, SW_NOP,        1'b1, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_MOTOR_ON,   1'b0, 8'h00, 8'h00);
    add_access(REQ_SWITCH, SW_MOTOR_OFF,  1'b0, 8'h00, 8'h00);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_idle();
        case (ph)
          1: begin
            write_reg(ADDR_MOTOR_OFF_DELAY, 32'd1);
            write_reg(ADDR_MAX_HALF_TRACK, 32'd127);
          end
          2: begin
            // lowered below the head position left by the previous phase
            write_reg(ADDR_MOTOR_OFF_DELAY, 32'd255);
            write_reg(ADDR_MAX_HALF_TRACK, 32'd1);
          end
          3: begin
            write_reg(ADDR_MOTOR_OFF_DELAY, 32'd4);
            write_reg(ADDR_MAX_HALF_TRACK, 32'd40);
          end
          4: begin
            write_reg(ADDR_MOTOR_OFF_DELAY, 32'($urandom_range(1, 255)));
            write_reg(ADDR_MAX_HALF_TRACK, 32'($urandom_range(1, 127)));
          end
          default: begin
            write_reg(ADDR_MOTOR_OFF_DELAY, 32'd2);
            write_reg(ADDR_MAX_HALF_TRACK, 32'd127);
          end
        endcase
      end
      send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 53 : 0;
      recv_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 12 : 0;
      target = stim_q.size() + ITEMS_PER_PHASE;
      if (ph == 1) add_seek(1'b1, 140, 1'b0);
      else add_seek(1'($urandom_range(0, 1)), $urandom_range(5, 60), 1'b0);
      while (stim_q.size() < target) add_burst();
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (mismatches == 0 && status_q.size() == 0)
      $display("floppy_soft_switch_controller_unit test passed");
    else
      $display("floppy_soft_switch_controller_unit test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/fssc_pkg.sv
rtl/fssc_cfg.sv
rtl/fssc_core.sv
rtl/floppy_soft_switch_controller_unit.sv
sim/floppy_soft_switch_controller_unit_tb.sv
